### sv/pwmaf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pwmaf_pkg
// shared constants, register codes and the moving-average level table
// ----------------------------------------------------------------------------
package pwmaf_pkg;

    localparam int WINDOW    = 10;
    localparam int CNT_W     = $clog2(WINDOW + 1);
    localparam int TBL_DEPTH = 2 ** CNT_W;

    localparam int LEVEL_W  = 17;
    localparam int DAC_W    = 13;
    localparam int WEIGHT_W = 16;
    localparam int FRAC_W   = 16;
    localparam int PROD_W   = LEVEL_W + DAC_W;
    localparam int EWA_W    = WEIGHT_W + LEVEL_W;

    localparam logic [LEVEL_W-1:0]  Q16_ONE      = 17'h10000;
    localparam logic [DAC_W-1:0]    DAC_FULL_MV  = 13'd4500;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd58982;

    typedef enum logic [0:0] {
        REG_FILTER_MODE      = 1'b0,
        REG_SMOOTHING_WEIGHT = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        MODE_MOVING_AVG  = 1'b0,
        MODE_EXPONENTIAL = 1'b1
    } filter_mode_t;

    typedef logic [LEVEL_W-1:0] level_table_t [TBL_DEPTH];

    // count of ones to q16 level, truncated
    function automatic level_table_t build_level_table();
        level_table_t tbl;
        for (int i = 0; i < TBL_DEPTH; i++)
        begin
            if (i <= WINDOW)
                tbl[i] = LEVEL_W'((i * 65536) / WINDOW);
            else
                tbl[i] = '0;
        end
        return tbl;
    endfunction

    localparam level_table_t LEVEL_TABLE = build_level_table();

endpackage
`default_nettype wire

### sv/pwm_averaging_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pwm_averaging_filter
// Turns sampled pwm bits into a q16 level and a dac value in millivolts.
// One sample request is taken every clock cycle unless both stages are full
// and the output stalls; each yields one result. The first stage updates the
// window of sample cells or the exponential average (one 16x17 multiply), the
// second scales the level to millivolts (one 17x13 multiply). A result waiting
// at the output does not stop the next sample from entering the first stage.
// ----------------------------------------------------------------------------
module pwm_averaging_filter (
    input  logic                           clk,
    input  logic                           rst_n,
    // config write port
    input  logic                           cfg_we,
    input  pwmaf_pkg::cfg_reg_t            cfg_index,
    input  logic [pwmaf_pkg::WEIGHT_W-1:0] cfg_data,
    // sample requests
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [0] sample_bit
    // results
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [31:0]                    m_tdata    // [16:0] level_q16, [29:17] dac_millivolts
);
    import pwmaf_pkg::*;

    filter_mode_t        mode_reg;
    logic [WEIGHT_W-1:0] weight_reg;

    logic               sample_bit;
    logic               accept;
    logic               out_free;
    logic               ma_shift;
    logic               ewa_update;
    logic [LEVEL_W-1:0] ma_level;
    logic [LEVEL_W-1:0] ewa_level;
    logic [LEVEL_W-1:0] level_in;

    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic [LEVEL_W-1:0] s1_level_reg;

    logic               m_valid_reg;
    logic               m_valid_next;
    logic [LEVEL_W-1:0] m_level_reg;
    logic [DAC_W-1:0]   m_dac_reg;
    logic [PROD_W-1:0]  dac_product;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_MOVING_AVG;
            weight_reg <= WEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FILTER_MODE:      mode_reg   <= filter_mode_t'(cfg_data[0]);
                REG_SMOOTHING_WEIGHT: weight_reg <= cfg_data;
            endcase
        end
    end

    assign sample_bit = s_tdata[0];
    assign out_free   = !m_valid_reg || m_tready;
    assign s_tready   = !s1_valid_reg || out_free;
    assign accept     = s_tvalid && s_tready;
    assign ma_shift   = accept && (mode_reg == MODE_MOVING_AVG);
    assign ewa_update = accept && (mode_reg == MODE_EXPONENTIAL);

    pwmaf_window u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .shift_en   (ma_shift),
        .sample_bit (sample_bit),
        .level_next (ma_level)
    );

    pwmaf_ewa u_ewa (
        .clk        (clk),
        .rst_n      (rst_n),
        .update_en  (ewa_update),
        .sample_bit (sample_bit),
        .weight     (weight_reg),
        .value_next (ewa_level)
    );

    assign level_in = (mode_reg == MODE_EXPONENTIAL) ? ewa_level : ma_level;

    // stage valids
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        m_valid_next  = m_valid_reg;
        if (out_free)
        begin
            m_valid_next  = s1_valid_reg;
            s1_valid_next = 1'b0;
        end
        if (accept)
            s1_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // level to millivolts, truncated
    assign dac_product = PROD_W'(s1_level_reg) * PROD_W'(DAC_FULL_MV);

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_level_reg <= level_in;
        if (out_free && s1_valid_reg)
        begin
            m_level_reg <= s1_level_reg;
            m_dac_reg   <= dac_product[FRAC_W+DAC_W-1:FRAC_W];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_dac_reg, m_level_reg};

endmodule
`default_nettype wire

### sv/pwmaf_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pwmaf_cell
// one sample slot of the averaging window, passes its bit to the next slot
// ----------------------------------------------------------------------------
module pwmaf_cell (
    input  logic clk,
    input  logic rst_n,
    input  logic shift_en,
    input  logic bit_in,
    output logic bit_out
);

    logic bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bit_reg <= 1'b0;
        else if (shift_en)
            bit_reg <= bit_in;
    end

    assign bit_out = bit_reg;

endmodule
`default_nettype wire

### sv/pwmaf_window.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pwmaf_window
// moving-average window: chain of sample cells and a running count of ones
// ----------------------------------------------------------------------------
module pwmaf_window (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           shift_en,
    input  logic                           sample_bit,
    output logic [pwmaf_pkg::LEVEL_W-1:0]  level_next
);
    import pwmaf_pkg::*;

    logic [WINDOW:0]  chain;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign chain[0] = sample_bit;

    for (genvar i = 0; i < WINDOW; i++)
    begin : g_cell
        pwmaf_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (shift_en),
            .bit_in   (chain[i]),
            .bit_out  (chain[i+1])
        );
    end

    // oldest bit leaves the window, new bit enters
    assign count_next = count_reg - CNT_W'(chain[WINDOW]) + CNT_W'(sample_bit);
    assign level_next = LEVEL_TABLE[count_next];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (shift_en)
            count_reg <= count_next;
    end

endmodule
`default_nettype wire

### sv/pwmaf_ewa.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pwmaf_ewa
// exponentially weighted average in q16
// ----------------------------------------------------------------------------
module pwmaf_ewa (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           update_en,
    input  logic                           sample_bit,
    input  logic [pwmaf_pkg::WEIGHT_W-1:0] weight,
    output logic [pwmaf_pkg::LEVEL_W-1:0]  value_next
);
    import pwmaf_pkg::*;

    logic [LEVEL_W-1:0] value_reg;
    logic [EWA_W-1:0]   product;
    logic [LEVEL_W-1:0] kept;
    logic [LEVEL_W-1:0] fresh;

    assign product    = EWA_W'(weight) * EWA_W'(value_reg);
    assign kept       = product[EWA_W-1:FRAC_W];
    assign fresh      = sample_bit ? (Q16_ONE - LEVEL_W'(weight)) : '0;
    // sum stays within full scale
    assign value_next = kept + fresh;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            value_reg <= '0;
        else if (update_en)
            value_reg <= value_next;
    end

endmodule
`default_nettype wire

### tb/tb_pwm_averaging_filter.sv
// ----------------------------------------------------------------------------
// tb_pwm_averaging_filter
// Streams sampled pwm bits into the filter in both averaging modes and under
// many weights, predicts each level and dac value in the testbench, and checks
// every result in order while both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_pwm_averaging_filter;

    import pwmaf_pkg::*;

    localparam int WATCHDOG_LIMIT = 500;
    localparam int MAX_REPORTS    = 10;
    localparam int SETTLE_CYCLES  = 4;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [DAC_W-1:0]   dac_mv;
    } filter_result_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    cfg_reg_t            cfg_index;
    logic [WEIGHT_W-1:0] cfg_data;
    logic                s_tvalid;
    logic                s_tready;
    logic [7:0]          s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [31:0]         m_tdata;

    // filter state as the testbench sees it
    logic                win_cells [WINDOW];
    int unsigned         wr_pos;
    int unsigned         ones_cnt;
    logic [LEVEL_W-1:0]  ewa_level;
    filter_mode_t        cur_mode;
    logic [WEIGHT_W-1:0] cur_weight;

    filter_result_t      pending_levels [$];
    int                  fail_count = 0;
    int                  idle_cycles = 0;
    bit                  sender_gapless = 1'b0;
    bit                  sink_gapless = 1'b0;

    pwm_averaging_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic filter_result_t filter_sample(input logic smp);
        filter_result_t      res;
        logic [33:0]         prod;
        logic [33:0]         sum;
        logic [29:0]         scaled;
        begin
            if (cur_mode == MODE_MOVING_AVG)
            begin
                ones_cnt = ones_cnt - win_cells[wr_pos];
                win_cells[wr_pos] = smp;
                ones_cnt = ones_cnt + smp;
                wr_pos = (wr_pos + 1) % WINDOW;
                res.level = LEVEL_W'((ones_cnt * 65536) / WINDOW);
            end
            else
            begin
                prod = 34'(cur_weight) * 34'(ewa_level);
                sum = (prod >> 16) + (smp ? (34'(65536) - 34'(cur_weight)) : 34'd0);
                if (sum > 34'(65536))
                    sum = 34'(65536);
                ewa_level = LEVEL_W'(sum);
                res.level = ewa_level;
            end
            scaled = 30'(res.level) * 30'(4500);
            res.dac_mv = DAC_W'(scaled >> 16);
            return res;
        end
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    // sends one sample request; entered and left at a rising edge
    task automatic send_sample(input logic smp);
        int gap;
        begin
            gap = sender_gapless ? 0 : $urandom_range(0, 7);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= {7'b0, smp};
            do
                @(negedge clk);
            while (!s_tready);
            @(posedge clk);
            pending_levels.push_back(filter_sample(smp));
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_levels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [WEIGHT_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_FILTER_MODE:      cur_mode = filter_mode_t'(data[0]);
            REG_SMOOTHING_WEIGHT: cur_weight = data;
            default:              ;
        endcase
        @(posedge clk);
    endtask

    // sink side: per result a random stall, or none in gapless stretches
    initial
    begin
        int stall;
        m_tready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            stall = sink_gapless ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(negedge clk);
            while (!m_tvalid);
            @(posedge clk);
        end
    end

    // result check: handshake seen before the edge that completes it
    always @(negedge clk)
    begin
        filter_result_t want;
        filter_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.level  = m_tdata[16:0];
            got.dac_mv = m_tdata[29:17];
            if (pending_levels.size() == 0)
                note_failure($sformatf("unexpected result level=%0d dac=%0d",
                                       got.level, got.dac_mv));
            else
            begin
                want = pending_levels.pop_front();
                if (got.level !== want.level)
                    note_failure($sformatf("level mismatch: expected %0d, got %0d",
                                           want.level, got.level));
                if (got.dac_mv !== want.dac_mv)
                    note_failure($sformatf("dac mismatch: expected %0d, got %0d",
                                           want.dac_mv, got.dac_mv));
            end
        end
    end

    always @(negedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // full window, draining, and the moving average from reset
    task automatic test_window_fill();
        repeat (WINDOW) send_sample(1'b1);
        repeat (4) send_sample(1'b0);
        send_sample(1'b1);
    endtask

    // reset weight, zero weight, largest weight
    task automatic test_exponential_weights();
        drain_results();
        write_reg(REG_FILTER_MODE, 16'hFFFF);
        send_sample(1'b1);
        send_sample(1'b1);
        send_sample(1'b0);
        drain_results();
        write_reg(REG_SMOOTHING_WEIGHT, 16'h0000);
        send_sample(1'b1);
        send_sample(1'b0);
        send_sample(1'b1);
        drain_results();
        write_reg(REG_SMOOTHING_WEIGHT, 16'hFFFF);
        send_sample(1'b1);
        send_sample(1'b1);
    endtask

    // the idle mode keeps its state across a mode change
    task automatic test_mode_freeze();
        drain_results();
        write_reg(REG_FILTER_MODE, 16'hFFFE);
        send_sample(1'b1);
        send_sample(1'b0);
        drain_results();
        write_reg(REG_FILTER_MODE, 16'h0001);
        send_sample(1'b0);
    endtask

    // sender stops mid stream until every result is back
    task automatic test_drain_resume();
        drain_results();
        write_reg(REG_SMOOTHING_WEIGHT, 16'(WEIGHT_RESET));
        repeat (20) send_sample(1'($urandom_range(0, 1)));
        drain_results();
        repeat (20) send_sample(1'($urandom_range(0, 1)));
    endtask

    // pwm-like bit streams with noise, many settings
    task automatic test_random_pwm();
        int unsigned         period;
        int unsigned         duty;
        int unsigned         offset;
        int unsigned         count;
        logic                smp;
        logic [WEIGHT_W-1:0] wgt;
        bit                  noise_only;
        for (int phase = 0; phase < 10; phase++)
        begin
            drain_results();
            case ($urandom_range(0, 5))
                0:       wgt = 16'h0000;
                1:       wgt = 16'hFFFF;
                2:       wgt = 16'(WEIGHT_RESET);
                3:       wgt = 16'hFFFF - 16'($urandom_range(0, 64));
                default: wgt = 16'($urandom);
            endcase
            write_reg(REG_FILTER_MODE, {15'($urandom), 1'(phase % 2)});
            write_reg(REG_SMOOTHING_WEIGHT, wgt);
            sender_gapless = ($urandom_range(0, 3) == 0);
            sink_gapless   = ($urandom_range(0, 3) == 0);
            noise_only     = ($urandom_range(0, 4) == 0);
            period = $urandom_range(1, 24);
            duty   = $urandom_range(0, period);
            offset = $urandom_range(0, period - 1);
            count  = $urandom_range(90, 120);
            for (int unsigned k = 0; k < count; k++)
            begin
                if (noise_only)
                    smp = 1'($urandom_range(0, 1));
                else
                begin
                    smp = (((k + offset) % period) < duty);
                    if ($urandom_range(0, 15) == 0)
                        smp = ~smp;
                end
                send_sample(smp);
            end
        end
        sender_gapless = 1'b0;
        sink_gapless   = 1'b0;
    endtask

    initial
    begin
        for (int i = 0; i < WINDOW; i++)
            win_cells[i] = 1'b0;
        wr_pos     = 0;
        ones_cnt   = 0;
        ewa_level  = '0;
        cur_mode   = MODE_MOVING_AVG;
        cur_weight = WEIGHT_RESET;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_FILTER_MODE;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_window_fill();
        test_exponential_weights();
        test_mode_freeze();
        test_drain_resume();
        test_random_pwm();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### files.f
sv/pwmaf_pkg.sv
sv/pwmaf_cell.sv
sv/pwmaf_window.sv
sv/pwmaf_ewa.sv
sv/pwm_averaging_filter.sv
tb/tb_pwm_averaging_filter.sv
